// ===== hdl/mcu_dm_pkg.sv =====
// Shared types and constants for the microcontroller data memory with stack pointer.
// Used by the front, back and top-level modules; depends on nothing else.
package mcu_dm_pkg;

    localparam int DATA_W = 8;
    localparam int ADDR_W = 16;
    localparam int KIND_W = 2;
    localparam int MODE_W = 3;

    // Request modes as they arrive on the input stream.
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TAKE  = 3'd4;

    // Kind of the last touched cell.
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SRC  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEST = 2'd2;

    // Value returned for refused reads and pops.
    localparam logic [DATA_W-1:0] RD_FILL = 8'hff;

    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_PUSH  = 3'd2,
        OP_POP   = 3'd3,
        OP_TAKE  = 3'd4,
        OP_NOP   = 3'd5
    } t_op;

    // Classified request handed from the front to the back.
    typedef struct packed {
        t_op               op;
        logic              in_range;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_req;

    // One result transaction.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] rd;
    } t_res;

endpackage

// ===== hdl/mcu_dm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module mcu_dm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2304
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mcu_dm_front.sv =====
// Front end: accepts request transactions, decodes mode and address range,
// and holds them in a two-entry queue for the back end. Uses mcu_dm_pkg.
module mcu_dm_front
    import mcu_dm_pkg::*;
#(
    parameter int MEMORY_TOP = 2303
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,
    input  logic        i_clear_busy,
    input  logic        i_pop,
    output logic        o_req_valid,
    output t_req        o_req
);

    localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(MEMORY_TOP);

    t_req              r_q [2];
    logic              r_wr_ptr, n_wr_ptr;
    logic              r_rd_ptr, n_rd_ptr;
    logic [1:0]        r_count, n_count;

    logic [MODE_W-1:0] in_mode;
    logic [ADDR_W-1:0] in_addr;
    logic [DATA_W-1:0] in_data;
    t_req              in_req;
    logic              push;

    assign in_mode = i_s_axis_tdata[MODE_W-1:0];
    assign in_addr = i_s_axis_tdata[MODE_W+ADDR_W-1:MODE_W];
    assign in_data = i_s_axis_tdata[MODE_W+ADDR_W+DATA_W-1:MODE_W+ADDR_W];

    always_comb begin
        in_req.addr     = in_addr;
        in_req.data     = in_data;
        in_req.in_range = (in_addr <= TOP_ADDR);
        unique case (in_mode)
            MODE_READ:  in_req.op = OP_READ;
            MODE_WRITE: in_req.op = OP_WRITE;
            MODE_PUSH:  in_req.op = OP_PUSH;
            MODE_POP:   in_req.op = OP_POP;
            MODE_TAKE:  in_req.op = OP_TAKE;
            default:    in_req.op = OP_NOP;
        endcase
    end

    // No new transaction is taken while the memory is being cleared.
    assign o_s_axis_tready = !i_clear_busy && (r_count != 2'd2);
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_req_valid     = (r_count != 2'd0);
    assign o_req           = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_req;
        end
    end

endmodule

// ===== hdl/mcu_dm_back.sv =====
// Back end: clears the data memory after reset, then executes queued requests,
// keeping a shadow of the stack pointer bytes and the last touched cell.
// Uses mcu_dm_pkg and mcu_dm_ram.
module mcu_dm_back
    import mcu_dm_pkg::*;
#(
    parameter int MEMORY_TOP           = 2303,
    parameter int STACK_FLOOR          = 256,
    parameter int STACK_LOW_BYTE_ADDR  = 93,
    parameter int STACK_HIGH_BYTE_ADDR = 94
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  t_req        i_req,
    output logic        o_pop,
    output logic        o_clear_busy,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata
);

    localparam int                AW       = $clog2(MEMORY_TOP + 1);
    localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(MEMORY_TOP);
    localparam logic [ADDR_W-1:0] FLOOR    = ADDR_W'(STACK_FLOOR);
    localparam logic [ADDR_W-1:0] SP_LO    = ADDR_W'(STACK_LOW_BYTE_ADDR);
    localparam logic [ADDR_W-1:0] SP_HI    = ADDR_W'(STACK_HIGH_BYTE_ADDR);
    localparam logic [AW-1:0]     CLR_LAST = AW'(MEMORY_TOP);

    logic              r_clearing;
    logic [AW-1:0]     r_clr_addr;
    logic [ADDR_W-1:0] r_sp, n_sp;
    logic [ADDR_W-1:0] r_last_addr, n_last_addr;
    logic [KIND_W-1:0] r_last_kind, n_last_kind;

    logic              r_p_valid;
    logic              r_p_use_ram, n_p_use_ram;
    t_res              r_p_res, n_p_res;
    logic              r_out_valid;
    t_res              r_out;
    t_res              p_final;

    logic              issue, p_move;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_q;
    logic              op_we, op_re;
    logic [AW-1:0]     op_waddr, op_raddr;
    logic [ADDR_W-1:0] sp_inc, sp_dec;

    assign p_move       = r_p_valid && (!r_out_valid || i_m_axis_tready);
    assign issue        = i_req_valid && !r_clearing && (!r_p_valid || p_move);
    assign o_pop        = issue;
    assign o_clear_busy = r_clearing;
    assign sp_inc       = r_sp + ADDR_W'(1);
    assign sp_dec       = r_sp - ADDR_W'(1);

    // Execute one request. The pointer bytes are served from the shadow register,
    // so their copies in the RAM are never read.
    always_comb begin
        n_sp        = r_sp;
        n_last_addr = r_last_addr;
        n_last_kind = r_last_kind;
        op_we       = 1'b0;
        op_re       = 1'b0;
        op_waddr    = '0;
        op_raddr    = '0;
        n_p_use_ram = 1'b0;
        n_p_res     = '0;
        unique case (i_req.op)
            OP_READ: begin
                if (!i_req.in_range) begin
                    n_p_res.rd = RD_FILL;
                end else begin
                    n_last_addr = i_req.addr;
                    n_last_kind = KIND_SRC;
                    if (i_req.addr == SP_LO) begin
                        n_p_res.rd = r_sp[7:0];
                    end else if (i_req.addr == SP_HI) begin
                        n_p_res.rd = r_sp[15:8];
                    end else begin
                        op_re       = 1'b1;
                        op_raddr    = i_req.addr[AW-1:0];
                        n_p_use_ram = 1'b1;
                    end
                end
            end
            OP_WRITE: begin
                if (i_req.in_range) begin
                    op_we       = 1'b1;
                    op_waddr    = i_req.addr[AW-1:0];
                    n_last_addr = i_req.addr;
                    n_last_kind = KIND_DEST;
                    if (i_req.addr == SP_LO) begin
                        n_sp[7:0] = i_req.data;
                    end
                    if (i_req.addr == SP_HI) begin
                        n_sp[15:8] = i_req.data;
                    end
                end
            end
            OP_PUSH: begin
                if (r_sp > FLOOR) begin
                    // The data store is dropped above the top, but the pointer still moves.
                    op_we       = (r_sp <= TOP_ADDR);
                    op_waddr    = r_sp[AW-1:0];
                    n_sp        = sp_dec;
                    n_last_addr = r_sp;
                    n_last_kind = KIND_DEST;
                end
            end
            OP_POP: begin
                if (r_sp >= TOP_ADDR) begin
                    n_p_res.rd = RD_FILL;
                end else begin
                    n_sp        = sp_inc;
                    n_last_addr = sp_inc;
                    n_last_kind = KIND_SRC;
                    if (sp_inc == SP_LO) begin
                        n_p_res.rd = r_sp[7:0];
                    end else if (sp_inc == SP_HI) begin
                        n_p_res.rd = r_sp[15:8];
                    end else begin
                        op_re       = 1'b1;
                        op_raddr    = sp_inc[AW-1:0];
                        n_p_use_ram = 1'b1;
                    end
                end
            end
            OP_TAKE: begin
                n_p_res.addr = r_last_addr;
                n_p_res.kind = r_last_kind;
                n_last_addr  = '0;
                n_last_kind  = KIND_NONE;
            end
            OP_NOP: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = issue && op_we;
            ram_waddr = op_waddr;
            ram_wdata = i_req.data;
        end
        ram_re    = issue && op_re;
        ram_raddr = op_raddr;
    end

    mcu_dm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEMORY_TOP + 1)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // The RAM output only changes on a new read, so it holds while the result stalls.
    always_comb begin
        p_final = r_p_res;
        if (r_p_use_ram) begin
            p_final.rd = ram_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_sp        <= '0;
            r_last_addr <= '0;
            r_last_kind <= KIND_NONE;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == CLR_LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            if (issue) begin
                r_sp        <= n_sp;
                r_last_addr <= n_last_addr;
                r_last_kind <= n_last_kind;
            end
            if (issue) begin
                r_p_valid <= 1'b1;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
            end
            if (p_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_p_use_ram <= n_p_use_ram;
            r_p_res     <= n_p_res;
        end
        if (p_move) begin
            r_out <= p_final;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out.kind, r_out.addr, r_out.rd};

endmodule

// ===== hdl/mcu_data_memory_with_stack_top.sv =====
// Top level of the microcontroller data memory with memory-mapped stack pointer.
// Depends on mcu_dm_pkg, mcu_dm_front, mcu_dm_back and mcu_dm_ram.
//
// Usage:
//   The slave stream carries one request per transaction: read, write, push,
//   pop, or take-and-clear of the last touched cell. The master stream returns
//   exactly one result transaction per request, in request order.
//   After reset the data memory is swept to zero one byte per cycle, and
//   o_s_axis_tready stays low while the sweep runs. The stack pointer bytes
//   and the last-cell record reset to zero at once.
//   With an empty pipe, a request is executed, with its RAM access, once it
//   has entered the queue, and its result then moves from the result stage
//   into the output register. The RAM has a single write port and a single
//   registered read port, and each request uses at most one of them, so one
//   request per cycle is sustained while the receiver does not stall.
//   When the receiver stalls, the result stage, the output register and the
//   two-entry request queue fill up and then tready drops; nothing is lost.
module mcu_data_memory_with_stack_top
    import mcu_dm_pkg::*;
#(
    parameter int MEMORY_TOP           = 2303,
    parameter int STACK_FLOOR          = 256,
    parameter int STACK_LOW_BYTE_ADDR  = 93,
    parameter int STACK_HIGH_BYTE_ADDR = 94
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // From bit 0: mode[2:0], address[18:3], data_in[26:19], zeros above.
    input  logic [31:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // From bit 0: read_data[7:0], touched_addr[23:8], touched_kind[25:24], zeros above.
    output logic [31:0] o_m_axis_tdata
);

    logic req_valid;
    t_req req;
    logic pop;
    logic clear_busy;

    mcu_dm_front #(
        .MEMORY_TOP (MEMORY_TOP)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_clear_busy    (clear_busy),
        .i_pop           (pop),
        .o_req_valid     (req_valid),
        .o_req           (req)
    );

    mcu_dm_back #(
        .MEMORY_TOP           (MEMORY_TOP),
        .STACK_FLOOR          (STACK_FLOOR),
        .STACK_LOW_BYTE_ADDR  (STACK_LOW_BYTE_ADDR),
        .STACK_HIGH_BYTE_ADDR (STACK_HIGH_BYTE_ADDR)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_valid),
        .i_req           (req),
        .o_pop           (pop),
        .o_clear_busy    (clear_busy),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
